// ----- sv/salru_pkg.sv -----
// shared types and constants of the set-associative lru cache tracker
package salru_pkg;

  // field widths of the request and result items, configuration registers and line metadata
  localparam int CMD_W      = 2;
  localparam int ADDR_W     = 32;
  localparam int OUTCOME_W  = 2;
  localparam int COUNT_W    = 32;
  localparam int AGE_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int SET_BITS_W = 3;
  localparam int BLK_BITS_W = 5;
  localparam int WAYS_W     = 4;

  // oldest age a line can reach
  localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

  // access kinds; the unused code behaves as a load
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2
  } cmd_t;

  // access outcomes
  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_BITS   = 2'd0,
    REG_BLOCK_BITS = 2'd1,
    REG_WAYS       = 2'd2
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_t;

  // per-line replacement state kept in the metadata memory
  typedef struct packed {
    logic             valid;
    logic [AGE_W-1:0] age;
  } line_meta_t;

  // request payload
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  // result payload
  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [COUNT_W-1:0]   hit_total;
    logic [COUNT_W-1:0]   miss_total;
    logic [COUNT_W-1:0]   eviction_total;
    logic                 last;
  } out_item_t;

endpackage

// ----- sv/salru_ram.sv -----
// generic simple dual-port ram with registered read
module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/salru_set_update.sv -----
// tag compare, victim choice and age update over one set row
module salru_set_update #(
  parameter int MAX_WAYS = 8,
  parameter int TAG_W    = 32
) (
  input  logic [MAX_WAYS-1:0][TAG_W-1:0]        tag_row,
  input  salru_pkg::line_meta_t [MAX_WAYS-1:0]  meta_row,
  input  logic [TAG_W-1:0]                      tag,
  input  logic [$clog2(MAX_WAYS+1)-1:0]         nw,
  output logic [MAX_WAYS-1:0][TAG_W-1:0]        tag_row_nxt,
  output salru_pkg::line_meta_t [MAX_WAYS-1:0]  meta_row_nxt,
  output salru_pkg::outcome_t                   outcome
);

  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW_W  = $clog2(MAX_WAYS + 1);

  logic [MAX_WAYS-1:0] in_rng;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] free_vec;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    free_way;
  logic [WAY_W-1:0]    old_way;
  logic [WAY_W-1:0]    target;
  logic [salru_pkg::AGE_W:0] limit;

  // per-way match and free flags, limited to the ways in use
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_rng[w]   = NW_W'(w) < nw;
      hit_vec[w]  = in_rng[w] && meta_row[w].valid && (tag_row[w] == tag);
      free_vec[w] = in_rng[w] && !meta_row[w].valid;
    end
  end

  // lowest matching way, lowest free way and oldest way (lowest on a tie)
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    old_way  = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (free_vec[w]) begin
        free_way = WAY_W'(w);
      end
    end
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_rng[w] && (meta_row[w].age > meta_row[old_way].age)) begin
        old_way = WAY_W'(w);
      end
    end
  end

  // outcome, target way and the age bound for the others
  always_comb begin
    if (|hit_vec) begin
      outcome = salru_pkg::OUT_HIT;
      target  = hit_way;
      limit   = {1'b0, meta_row[hit_way].age};
    end else if (|free_vec) begin
      outcome = salru_pkg::OUT_FILL;
      target  = free_way;
      limit   = {1'b0, salru_pkg::AGE_MAX} + 1'b1;
    end else begin
      outcome = salru_pkg::OUT_EVICT;
      target  = old_way;
      limit   = {1'b0, meta_row[old_way].age};
    end
  end

  // new row contents
  always_comb begin
    tag_row_nxt  = tag_row;
    meta_row_nxt = meta_row;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_W'(w) == target) begin
        meta_row_nxt[w].valid = 1'b1;
        meta_row_nxt[w].age   = '0;
        if (outcome != salru_pkg::OUT_HIT) begin
          tag_row_nxt[w] = tag;
        end
      end else if (in_rng[w] && meta_row[w].valid
                   && ({1'b0, meta_row[w].age} < limit)
                   && (meta_row[w].age < salru_pkg::AGE_MAX)) begin
        meta_row_nxt[w].age = meta_row[w].age + 1'b1;
      end
    end
  end

endmodule

// ----- sv/set_assoc_lru_cache_tracker.sv -----
// top level: sequencer, set memories, configuration and hit/miss counters
// a load or store request is one access and a modify two, each access being one
// set-row read then one write-back; a new request is taken in the last write-back
// cycle of the previous one. each result strobes out_valid for one cycle, registered
// from the write-back of its access, and cannot be held off. after reset, busy stays
// high while the line metadata memory is cleared row by row
module set_assoc_lru_cache_tracker #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  salru_pkg::in_item_t                     in_data,
  output logic                                    out_valid,
  output salru_pkg::out_item_t                    out_data,
  input  logic                                    cfg_we,
  input  logic [salru_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_IW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NW_W     = $clog2(MAX_WAYS + 1);
  localparam int TAG_W    = ADDR_WIDTH;
  localparam int META_W   = MAX_WAYS * $bits(salru_pkg::line_meta_t);
  localparam logic [SET_IW-1:0] LAST_SET = SET_IW'(NUM_SETS - 1);

  salru_pkg::state_t state_r, state_nxt;

  logic [salru_pkg::SET_BITS_W-1:0] set_bits_r;
  logic [salru_pkg::BLK_BITS_W-1:0] block_bits_r;
  logic [salru_pkg::WAYS_W-1:0]     ways_r;

  logic [SET_IW-1:0]               clr_cnt_r;
  logic [salru_pkg::CMD_W-1:0]     cmd_r;
  logic [SET_IW-1:0]               set_r;
  logic [TAG_W-1:0]                tag_r;
  logic                            second_r;
  logic [salru_pkg::COUNT_W-1:0]   hits_r, misses_r, evictions_r;
  logic [salru_pkg::COUNT_W-1:0]   hits_nxt, misses_nxt, evictions_nxt;
  logic                            out_valid_r;
  salru_pkg::out_item_t            out_data_r;

  logic                            accept;
  logic                            finishing;
  logic                            meta_we;
  logic                            tag_we;
  logic [SET_IW-1:0]               meta_waddr;
  logic [SET_IW-1:0]               req_set;
  logic [TAG_W-1:0]                req_tag;
  logic [salru_pkg::SET_BITS_W-1:0] sb_eff;
  logic [NW_W-1:0]                 nw_eff;
  logic [5:0]                      tag_shift;
  logic [63:0]                     addr_m;
  logic [63:0]                     set_wide;
  logic [63:0]                     tag_wide;

  logic [MAX_WAYS-1:0][TAG_W-1:0]       tag_row, tag_row_nxt;
  salru_pkg::line_meta_t [MAX_WAYS-1:0] meta_row, meta_row_nxt, meta_wdata;
  salru_pkg::outcome_t                  outcome;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= '0;
      block_bits_r <= '0;
      ways_r       <= salru_pkg::WAYS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        salru_pkg::REG_SET_BITS:   set_bits_r   <= cfg_wdata[salru_pkg::SET_BITS_W-1:0];
        salru_pkg::REG_BLOCK_BITS: block_bits_r <= cfg_wdata[salru_pkg::BLK_BITS_W-1:0];
        salru_pkg::REG_WAYS:       ways_r       <= cfg_wdata[salru_pkg::WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective set bits and way count
  always_comb begin
    sb_eff = (int'(set_bits_r) > MAX_SET_BITS)
             ? salru_pkg::SET_BITS_W'(MAX_SET_BITS) : set_bits_r;
    if (ways_r == '0) begin
      nw_eff = NW_W'(1);
    end else if (int'(ways_r) > MAX_WAYS) begin
      nw_eff = NW_W'(MAX_WAYS);
    end else begin
      nw_eff = NW_W'(ways_r);
    end
  end

  // split the request address into set index and tag
  always_comb begin
    addr_m    = {32'd0, in_data.address} & ((64'd1 << ADDR_WIDTH) - 64'd1);
    tag_shift = 6'(block_bits_r) + 6'(sb_eff);
    set_wide  = '0;
    tag_wide  = '0;
    if (int'(block_bits_r) < ADDR_WIDTH) begin
      set_wide = (addr_m >> block_bits_r) & ((64'd1 << sb_eff) - 64'd1);
    end
    if (int'(tag_shift) < ADDR_WIDTH) begin
      tag_wide = addr_m >> tag_shift;
    end
    req_set = set_wide[SET_IW-1:0];
    req_tag = tag_wide[TAG_W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      salru_pkg::ST_CLEAR:  if (clr_cnt_r == LAST_SET) state_nxt = salru_pkg::ST_IDLE;
      salru_pkg::ST_IDLE:   if (start) state_nxt = salru_pkg::ST_READ;
      salru_pkg::ST_READ:   state_nxt = salru_pkg::ST_UPDATE;
      salru_pkg::ST_UPDATE: begin
        if (!finishing) begin
          state_nxt = salru_pkg::ST_READ;
        end else if (start) begin
          state_nxt = salru_pkg::ST_READ;
        end else begin
          state_nxt = salru_pkg::ST_IDLE;
        end
      end
      default: state_nxt = salru_pkg::ST_CLEAR;
    endcase
  end

  // control outputs of the sequencer
  always_comb begin
    finishing  = (cmd_r != salru_pkg::CMD_MODIFY) || second_r;
    busy       = 1'b1;
    meta_we    = 1'b0;
    tag_we     = 1'b0;
    meta_waddr = set_r;
    meta_wdata = meta_row_nxt;
    unique case (state_r)
      salru_pkg::ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_cnt_r;
        meta_wdata = '0;
      end
      salru_pkg::ST_IDLE: busy = 1'b0;
      salru_pkg::ST_READ: ;
      salru_pkg::ST_UPDATE: begin
        meta_we = 1'b1;
        tag_we  = 1'b1;
        busy    = !finishing;
      end
      default: ;
    endcase
    accept = start && !busy;
  end

  // state and clear counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= salru_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == salru_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // latched request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
    end else if (accept) begin
      second_r <= 1'b0;
    end else if (state_r == salru_pkg::ST_UPDATE) begin
      second_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data.cmd;
      set_r <= req_set;
      tag_r <= req_tag;
    end
  end

  // set memories: tags and metadata, one row per set
  salru_ram #(
    .WIDTH (MAX_WAYS * TAG_W),
    .DEPTH (NUM_SETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (set_r),
    .wdata (tag_row_nxt),
    .raddr (set_r),
    .rdata (tag_row)
  );

  salru_ram #(
    .WIDTH (META_W),
    .DEPTH (NUM_SETS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (set_r),
    .rdata (meta_row)
  );

  // lookup and replacement update of the set row
  salru_set_update #(
    .MAX_WAYS (MAX_WAYS),
    .TAG_W    (TAG_W)
  ) u_set_update (
    .tag_row      (tag_row),
    .meta_row     (meta_row),
    .tag          (tag_r),
    .nw           (nw_eff),
    .tag_row_nxt  (tag_row_nxt),
    .meta_row_nxt (meta_row_nxt),
    .outcome      (outcome)
  );

  // running totals after this access
  always_comb begin
    hits_nxt      = hits_r;
    misses_nxt    = misses_r;
    evictions_nxt = evictions_r;
    case (outcome)
      salru_pkg::OUT_HIT:   hits_nxt = hits_r + 1'b1;
      salru_pkg::OUT_FILL:  misses_nxt = misses_r + 1'b1;
      salru_pkg::OUT_EVICT: begin
        misses_nxt    = misses_r + 1'b1;
        evictions_nxt = evictions_r + 1'b1;
      end
      default: ;
    endcase
  end

  // counters and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r      <= '0;
      misses_r    <= '0;
      evictions_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == salru_pkg::ST_UPDATE);
      if (state_r == salru_pkg::ST_UPDATE) begin
        hits_r      <= hits_nxt;
        misses_r    <= misses_nxt;
        evictions_r <= evictions_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state_r == salru_pkg::ST_UPDATE) begin
      out_data_r.outcome        <= outcome;
      out_data_r.hit_total      <= hits_nxt;
      out_data_r.miss_total     <= misses_nxt;
      out_data_r.eviction_total <= evictions_nxt;
      out_data_r.last           <= finishing;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
